// ----- design/cfas_pkg.sv -----
// shared types, constants and saturating helpers for the coupled-field stencil
package cfas_pkg;

	localparam int FIELD_W = 32;
	localparam int Q_W = 64;
	localparam int FRAC_W = 20;
	localparam int NUM_LANES = 3;
	// dividend is the 64-bit magnitude with the fraction bits appended
	localparam int DIV_STEPS = Q_W + FRAC_W;

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic signed [FIELD_W-1:0] field_t;

	localparam q_t QLIM = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q_t ONE_Q = 64'sd1048576;

	typedef enum logic [2:0] {
		REG_MU    = 3'd0,
		REG_KAPPA = 3'd1,
		REG_INVDX = 3'd2,
		REG_UPM   = 3'd3,
		REG_DNM   = 3'd4,
		REG_MASK  = 3'd5
	} reg_idx_t;

	localparam logic [1:0] CELLS_NONE = 2'd0;
	localparam logic [1:0] CELLS_ONE  = 2'd1;
	localparam logic [1:0] CELLS_MANY = 2'd2;

	// saturating add, clamps to +-(2^63-1)
	function automatic q_t qadd(input q_t a, input q_t b);
		logic signed [Q_W:0] s;
		q_t r;
		s = $signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b});
		if (s > $signed({1'b0, QLIM}))
			r = QLIM;
		else if (s < -$signed({1'b0, QLIM}))
			r = -QLIM;
		else
			r = s[Q_W-1:0];
		return r;
	endfunction

	function automatic field_t sat32(input q_t v);
		field_t r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[FIELD_W-1:0];
		return r;
	endfunction

	function automatic logic [Q_W-1:0] qmag(input q_t v);
		logic [Q_W-1:0] r;
		r = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
		return r;
	endfunction

endpackage

// ----- design/coupled_field_accel_stencil_top.sv -----
// top level: register port, cell window, shared product sequencer, three lanes, output word
//
// Usage: one lattice line streams in, one cell per input word (field_one..three, line_end).
// Input words use in_valid/in_stall, result words use out_valid/out_stall; a word moves at
// a rising edge with valid high and stall low. Coefficients sit behind an APB-style port
// (six 32-bit registers at byte offsets 0..20); the user must write them only while the
// block is idle, which the block itself does not enforce. Results lag one cell: the first
// cell of a line gives no result, the second gives a zero word for the first cell, each
// later cell gives the stencil result of the previous cell. A line_end word adds a closing
// zero word with line_done set and clears the window. Throughput: one item at a time.
// An interior cell runs eight shared 64-bit products (the three pairwise products, P, its
// square, the denominator and the coupling factor), then in every lane three products and
// the 84-step serial divider. Cells without stencil work skip the products and the lanes.
// A finished word waits in the output register while the next cell is taken; a stalled
// receiver holds the word and the block waits only when it needs that register again.
// Reset clears the window and the output register and loads the default coefficients.
module coupled_field_accel_stencil_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [31:0]      field_one,
	input  logic signed [31:0]      field_two,
	input  logic signed [31:0]      field_three,
	input  logic                    line_end,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      accel_one,
	output logic signed [31:0]      accel_two,
	output logic signed [31:0]      accel_three,
	output logic                    line_done
);

	localparam int NL = cfas_pkg::NUM_LANES;

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_COM  = 5'b00010,
		T_LANE = 5'b00100,
		T_EMIT = 5'b01000,
		T_LAST = 5'b10000
	} top_state_t;

	typedef enum logic [2:0] {
		CS_P12 = 3'd0,
		CS_P13 = 3'd1,
		CS_P23 = 3'd2,
		CS_P   = 3'd3,
		CS_PP  = 3'd4,
		CS_KAP = 3'd5,
		CS_DEN = 3'd6,
		CS_T   = 3'd7
	} com_step_t;

	// configuration
	logic [31:0] mu_q;
	logic [30:0] kappa_q, invdx_q, upm_q, dnm_q;
	logic [2:0]  mask_q;
	logic        cfg_wr;
	cfas_pkg::reg_idx_t cfg_idx;

	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = cfas_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= 32'hFEC0_0000;
			kappa_q <= 31'd20971520;
			invdx_q <= 31'd419430400;
			upm_q <= 31'd1048576;
			dnm_q <= 31'd1048576;
			mask_q <= 3'd4;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cfas_pkg::REG_MU:    mu_q <= pwdata;
				cfas_pkg::REG_KAPPA: kappa_q <= pwdata[30:0];
				cfas_pkg::REG_INVDX: invdx_q <= pwdata[30:0];
				cfas_pkg::REG_UPM:   upm_q <= pwdata[30:0];
				cfas_pkg::REG_DNM:   dnm_q <= pwdata[30:0];
				cfas_pkg::REG_MASK:  mask_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			cfas_pkg::REG_MU:    prdata = mu_q;
			cfas_pkg::REG_KAPPA: prdata = {1'b0, kappa_q};
			cfas_pkg::REG_INVDX: prdata = {1'b0, invdx_q};
			cfas_pkg::REG_UPM:   prdata = {1'b0, upm_q};
			cfas_pkg::REG_DNM:   prdata = {1'b0, dnm_q};
			cfas_pkg::REG_MASK:  prdata = {29'd0, mask_q};
			default:             prdata = '0;
		endcase
	end

	// window and sequencer
	top_state_t       st_q;
	com_step_t        step_q;
	cfas_pkg::field_t cur_q [NL];
	cfas_pkg::field_t prev_q [NL];
	cfas_pkg::field_t pprev_q [NL];
	logic             end_q;
	logic [1:0]       cells_q;
	logic             mgo_q, lgo_q;
	logic [NL-1:0]    lseen_q;
	cfas_pkg::q_t     p12_q, p13_q, p23_q, p_q, pp_q, base_q, den_q, t_q;

	logic             ovalid_q, odone_q;
	cfas_pkg::field_t oacc_q [NL];

	cfas_pkg::field_t in_f [NL];
	cfas_pkg::q_t     opa, opb, mres, negmu;
	logic             mdone, ofree;
	logic [NL-1:0]    ldone;
	cfas_pkg::field_t lacc [NL];
	cfas_pkg::q_t     dpv [NL];

	assign in_f[0] = field_one;
	assign in_f[1] = field_two;
	assign in_f[2] = field_three;

	assign negmu = -cfas_pkg::Q_W'($signed(mu_q));
	assign ofree = !ovalid_q || !out_stall;

	always_comb begin
		case (step_q)
			CS_P12: begin opa = 64'(prev_q[0]); opb = 64'(prev_q[1]); end
			CS_P13: begin opa = 64'(prev_q[0]); opb = 64'(prev_q[2]); end
			CS_P23: begin opa = 64'(prev_q[1]); opb = 64'(prev_q[2]); end
			CS_P:   begin opa = p12_q;          opb = 64'(prev_q[2]); end
			CS_PP:  begin opa = p_q;            opb = p_q;            end
			CS_KAP: begin opa = {33'd0, kappa_q}; opb = pp_q;         end
			CS_DEN: begin opa = base_q;         opb = base_q;         end
			CS_T:   begin opa = negmu;          opb = p_q;            end
			default: begin opa = '0;            opb = '0;             end
		endcase
	end

	cfas_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mgo_q), .a(opa), .b(opb),
		.done(mdone), .res(mres)
	);

	// lane k takes the product of the other two fields
	assign dpv[0] = p23_q;
	assign dpv[1] = p13_q;
	assign dpv[2] = p12_q;

	for (genvar k = 0; k < NL; k++) begin : g_lane
		cfas_lane u_lane (
			.clk(clk), .arst_n(arst_n), .start(lgo_q),
			.left(pprev_q[k]), .center(prev_q[k]), .right(cur_q[k]),
			.mass_sq(mask_q[k] ? dnm_q : upm_q), .inv_dx(invdx_q),
			.coup(t_q), .dprod(dpv[k]), .den(den_q),
			.done(ldone[k]), .accel(lacc[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			step_q <= CS_P12;
			end_q <= 1'b0;
			cells_q <= cfas_pkg::CELLS_NONE;
			mgo_q <= 1'b0;
			lgo_q <= 1'b0;
			lseen_q <= '0;
			ovalid_q <= 1'b0;
			odone_q <= 1'b0;
			p12_q <= '0; p13_q <= '0; p23_q <= '0; p_q <= '0;
			pp_q <= '0; base_q <= '0; den_q <= '0; t_q <= '0;
			for (int k = 0; k < NL; k++) begin
				cur_q[k] <= '0;
				prev_q[k] <= '0;
				pprev_q[k] <= '0;
				oacc_q[k] <= '0;
			end
		end else begin
			mgo_q <= 1'b0;
			lgo_q <= 1'b0;
			if (!out_stall)
				ovalid_q <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (in_valid) begin
						for (int k = 0; k < NL; k++)
							cur_q[k] <= in_f[k];
						end_q <= line_end;
						case (cells_q)
							cfas_pkg::CELLS_NONE: begin
								if (line_end) begin
									st_q <= T_LAST;
								end else begin
									for (int k = 0; k < NL; k++)
										prev_q[k] <= in_f[k];
									cells_q <= cfas_pkg::CELLS_ONE;
								end
							end
							cfas_pkg::CELLS_ONE: st_q <= T_EMIT;
							default: begin
								step_q <= CS_P12;
								mgo_q <= 1'b1;
								st_q <= T_COM;
							end
						endcase
					end
				end
				T_COM: begin
					if (mdone) begin
						case (step_q)
							CS_P12: p12_q <= mres;
							CS_P13: p13_q <= mres;
							CS_P23: p23_q <= mres;
							CS_P:   p_q <= mres;
							CS_PP:  pp_q <= mres;
							CS_KAP: base_q <= cfas_pkg::qadd(cfas_pkg::ONE_Q, mres);
							CS_DEN: den_q <= mres;
							default: t_q <= mres;
						endcase
						if (step_q == CS_T) begin
							lgo_q <= 1'b1;
							lseen_q <= '0;
							st_q <= T_LANE;
						end else begin
							step_q <= com_step_t'(step_q + 3'd1);
							mgo_q <= 1'b1;
						end
					end
				end
				T_LANE: begin
					lseen_q <= lseen_q | ldone;
					if (&(lseen_q | ldone))
						st_q <= T_EMIT;
				end
				T_EMIT: begin
					if (ofree) begin
						ovalid_q <= 1'b1;
						odone_q <= 1'b0;
						for (int k = 0; k < NL; k++)
							oacc_q[k] <= (cells_q == cfas_pkg::CELLS_MANY) ? lacc[k] : '0;
						if (end_q) begin
							st_q <= T_LAST;
						end else begin
							for (int k = 0; k < NL; k++) begin
								pprev_q[k] <= prev_q[k];
								prev_q[k] <= cur_q[k];
							end
							cells_q <= cfas_pkg::CELLS_MANY;
							st_q <= T_IDLE;
						end
					end
				end
				T_LAST: begin
					if (ofree) begin
						ovalid_q <= 1'b1;
						odone_q <= 1'b1;
						for (int k = 0; k < NL; k++) begin
							oacc_q[k] <= '0;
							prev_q[k] <= '0;
							pprev_q[k] <= '0;
						end
						cells_q <= cfas_pkg::CELLS_NONE;
						st_q <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign in_stall = (st_q != T_IDLE);
	assign out_valid = ovalid_q;
	assign accel_one = oacc_q[0];
	assign accel_two = oacc_q[1];
	assign accel_three = oacc_q[2];
	assign line_done = odone_q;

endmodule

// ----- design/cfas_mul.sv -----
// Q.20 saturating product built from four 32x32 partial products
module cfas_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cfas_pkg::q_t  a,
	input  cfas_pkg::q_t  b,
	output logic          done,
	output cfas_pkg::q_t  res
);

	logic [63:0]  xm_q, ym_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic [63:0]  prod_q;
	logic [1:0]   sh_q;
	logic         pv_q;
	logic [127:0] acc_q;
	logic         done_q;

	logic [31:0]  pa, pb;
	logic [1:0]   psh;
	logic [127:0] addend;
	cfas_pkg::q_t mag_r;

	always_comb begin
		case (cnt_q)
			3'd0: begin
				pa = xm_q[31:0];  pb = ym_q[31:0];  psh = 2'd0;
			end
			3'd1: begin
				pa = xm_q[31:0];  pb = ym_q[63:32]; psh = 2'd1;
			end
			3'd2: begin
				pa = xm_q[63:32]; pb = ym_q[31:0];  psh = 2'd1;
			end
			3'd3: begin
				pa = xm_q[63:32]; pb = ym_q[63:32]; psh = 2'd2;
			end
			default: begin
				pa = '0; pb = '0; psh = 2'd0;
			end
		endcase
	end

	always_comb begin
		case (sh_q)
			2'd0:    addend = {64'd0, prod_q};
			2'd1:    addend = {32'd0, prod_q, 32'd0};
			default: addend = {prod_q, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xm_q <= '0;
			ym_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			prod_q <= '0;
			sh_q <= '0;
			pv_q <= 1'b0;
			acc_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				xm_q <= cfas_pkg::qmag(a);
				ym_q <= cfas_pkg::qmag(b);
				neg_q <= a[63] ^ b[63];
				acc_q <= '0;
				cnt_q <= '0;
				pv_q <= 1'b0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q < 3'd4) begin
					prod_q <= pa * pb;
					sh_q <= psh;
					pv_q <= 1'b1;
				end else begin
					pv_q <= 1'b0;
				end
				if (pv_q)
					acc_q <= acc_q + addend;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// drop the fraction bits, saturate when the product reaches 2^63 after the shift
	assign mag_r = (|acc_q[127:83]) ? cfas_pkg::QLIM : {1'b0, acc_q[82:20]};
	assign res = neg_q ? -mag_r : mag_r;
	assign done = done_q;

endmodule

// ----- design/cfas_div.sv -----
// bit-serial restoring divider giving a saturated Q.20 quotient
module cfas_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cfas_pkg::q_t  num,
	input  cfas_pkg::q_t  den,
	output logic          done,
	output cfas_pkg::q_t  res
);

	localparam int DW = cfas_pkg::DIV_STEPS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [63:0]   rem_q;
	logic [63:0]   d_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [64:0]   trial;
	logic          fits;
	cfas_pkg::q_t  mag_r;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q <= '0;
			rem_q <= '0;
			d_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q <= {cfas_pkg::qmag(num), {cfas_pkg::FRAC_W{1'b0}}};
				rem_q <= '0;
				d_q <= den;
				neg_q <= num[63];
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits)
					rem_q <= 64'(trial - {1'b0, d_q});
				else
					rem_q <= trial[63:0];
				dvd_q <= {dvd_q[DW-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign mag_r = (|dvd_q[DW-1:63]) ? cfas_pkg::QLIM : {1'b0, dvd_q[62:0]};
	assign res = neg_q ? -mag_r : mag_r;
	assign done = done_q;

endmodule

// ----- design/cfas_lane.sv -----
// one field's acceleration: laplacian, mass term and coupling quotient
module cfas_lane (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cfas_pkg::field_t left,
	input  cfas_pkg::field_t center,
	input  cfas_pkg::field_t right,
	input  logic [30:0]      mass_sq,
	input  logic [30:0]      inv_dx,
	input  cfas_pkg::q_t     coup,
	input  cfas_pkg::q_t     dprod,
	input  cfas_pkg::q_t     den,
	output logic             done,
	output cfas_pkg::field_t accel
);

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_LAP  = 5'b00010,
		L_MASS = 5'b00100,
		L_CPL  = 5'b01000,
		L_DIV  = 5'b10000
	} lane_state_t;

	lane_state_t  st_q;
	logic         mgo_q, dgo_q, done_q;
	cfas_pkg::q_t ma_q, mb_q, s_q, dnum_q;

	logic         mdone, ddone;
	cfas_pkg::q_t mres, dres, lap;

	assign lap = cfas_pkg::Q_W'(right) - (cfas_pkg::Q_W'(center) <<< 1)
		+ cfas_pkg::Q_W'(left);

	cfas_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mgo_q), .a(ma_q), .b(mb_q),
		.done(mdone), .res(mres)
	);

	cfas_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dgo_q), .num(dnum_q), .den(den),
		.done(ddone), .res(dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			mgo_q <= 1'b0;
			dgo_q <= 1'b0;
			done_q <= 1'b0;
			ma_q <= '0;
			mb_q <= '0;
			s_q <= '0;
			dnum_q <= '0;
		end else begin
			mgo_q <= 1'b0;
			dgo_q <= 1'b0;
			done_q <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (start) begin
						ma_q <= lap;
						mb_q <= {33'd0, inv_dx};
						mgo_q <= 1'b1;
						st_q <= L_LAP;
					end
				end
				L_LAP: begin
					if (mdone) begin
						s_q <= mres;
						ma_q <= {33'd0, mass_sq};
						mb_q <= cfas_pkg::Q_W'(center);
						mgo_q <= 1'b1;
						st_q <= L_MASS;
					end
				end
				L_MASS: begin
					if (mdone) begin
						s_q <= cfas_pkg::qadd(s_q, -mres);
						ma_q <= coup;
						mb_q <= dprod;
						mgo_q <= 1'b1;
						st_q <= L_CPL;
					end
				end
				L_CPL: begin
					if (mdone) begin
						dnum_q <= mres;
						dgo_q <= 1'b1;
						st_q <= L_DIV;
					end
				end
				L_DIV: begin
					if (ddone) begin
						s_q <= cfas_pkg::qadd(s_q, dres);
						done_q <= 1'b1;
						st_q <= L_IDLE;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign accel = cfas_pkg::sat32(s_q);

endmodule
